>>> design/sirs_pkg.sv
// ----------------------------------------------------------------------------
// sirs_pkg: shared types and constants
// Widths, symbol codes, register indexes, sequencer states and the status
// bundles exchanged between the sequencer and its shared units.
// ----------------------------------------------------------------------------
package sirs_pkg;

  localparam int DATA_W    = 32;
  localparam int RADIX_W   = 5;
  localparam int DIGIT_W   = 4;
  localparam int SYM_W     = 8;
  localparam int TAB_SIZE  = 16;
  localparam int CNT_W     = 6;
  localparam int ADDR_W    = 5;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 64;
  localparam int SLICE_W   = 8;
  localparam int DIV_STEPS = DATA_W / SLICE_W;
  localparam int STEP_W    = $clog2(DIV_STEPS);
  localparam int TIDX_W    = $clog2(TAB_SIZE);

  localparam logic [RADIX_W-1:0] MIN_RADIX   = RADIX_W'(2);
  localparam logic [RADIX_W-1:0] MAX_RADIX   = RADIX_W'(16);
  localparam logic [CNT_W-1:0]   MAX_DIGITS  = CNT_W'(32);

  localparam logic [SYM_W-1:0] SYM_MINUS = 8'h2D;
  localparam logic [SYM_W-1:0] SYM_PLUS  = 8'h2B;
  localparam logic [SYM_W-1:0] SYM_NUL   = 8'h00;

  localparam logic [RADIX_W-1:0]   RADIX_RESET    = RADIX_W'(10);
  localparam logic [CFG_DAT_W-1:0] SYM_LOW_RESET  = 64'h3736353433323130;
  localparam logic [CFG_DAT_W-1:0] SYM_HIGH_RESET = 64'h6665646362613938;

  typedef logic [TAB_SIZE-1:0][SYM_W-1:0] sym_table_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RADIX    = 2'd0,
    REG_SYM_LOW  = 2'd1,
    REG_SYM_HIGH = 2'd2
  } cfg_reg_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_DIV,
    S_SIGN,
    S_READ,
    S_DIGIT
  } state_e;

  typedef struct packed {
    logic busy;
    logic done;
    logic ok;
  } chk_status_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

>>> design/sirs_if.sv
// ----------------------------------------------------------------------------
// sirs_if: valid/ready channels of the radix symbol unit
// Input value channel, output symbol channel and register write channel.
// ----------------------------------------------------------------------------
interface sirs_value_if;
  logic                               valid;
  logic                               ready;
  logic signed [sirs_pkg::DATA_W-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface sirs_symbol_if;
  logic                        valid;
  logic                        ready;
  logic [sirs_pkg::SYM_W-1:0]  symbol;
  logic                        last;

  modport source (output valid, output symbol, output last, input ready);
  modport sink   (input valid, input symbol, input last, output ready);
endinterface

interface sirs_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [sirs_pkg::CFG_IDX_W-1:0]    index;
  logic [sirs_pkg::CFG_DAT_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> design/sirs_divider.sv
// ----------------------------------------------------------------------------
// sirs_divider: iterative divide of a 32-bit magnitude by a small radix
// Restoring division, eight quotient bits per cycle.
// ----------------------------------------------------------------------------
module sirs_divider (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [sirs_pkg::DATA_W-1:0]   dividend_i,
  input  logic [sirs_pkg::RADIX_W-1:0]  divisor_i,
  output sirs_pkg::div_status_t         status_o,
  output logic [sirs_pkg::DATA_W-1:0]   quotient_o,
  output logic [sirs_pkg::DIGIT_W-1:0]  remainder_o
);
  import sirs_pkg::*;

  logic                busy_q, busy_d;
  logic [STEP_W-1:0]   step_q, step_d;
  logic [DATA_W-1:0]   acc_q, acc_d;
  logic [DIGIT_W-1:0]  rem_q, rem_d;

  logic [DIGIT_W-1:0]  rem_c;
  logic [RADIX_W-1:0]  trial;
  logic [SLICE_W-1:0]  qbyte;
  logic                last_step;

  // Eight chained compare/subtract steps on the narrow remainder.
  always_comb begin
    rem_c = rem_q;
    trial = '0;
    qbyte = '0;
    for (int b = 0; b < SLICE_W; b++) begin
      trial = {rem_c, acc_q[DATA_W-1-b]};
      if (trial >= divisor_i) begin
        qbyte[SLICE_W-1-b] = 1'b1;
        rem_c = DIGIT_W'(trial - divisor_i);
      end else begin
        rem_c = trial[DIGIT_W-1:0];
      end
    end
  end

  assign last_step = busy_q && (step_q == STEP_W'(DIV_STEPS - 1));

  always_comb begin
    busy_d = busy_q;
    step_d = step_q;
    acc_d  = acc_q;
    rem_d  = rem_q;
    if (start_i && !busy_q) begin
      busy_d = 1'b1;
      step_d = '0;
      acc_d  = dividend_i;
      rem_d  = '0;
    end else if (busy_q) begin
      acc_d  = {acc_q[DATA_W-SLICE_W-1:0], qbyte};
      rem_d  = rem_c;
      step_d = step_q + STEP_W'(1);
      if (last_step) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    rem_q <= rem_d;
  end

  assign status_o.busy = busy_q;
  assign status_o.done = last_step;
  assign quotient_o    = {acc_q[DATA_W-SLICE_W-1:0], qbyte};
  assign remainder_o   = rem_c;

endmodule

>>> design/sirs_sym_check.sv
// ----------------------------------------------------------------------------
// sirs_sym_check: symbol set validation
// Checks the radix range, then one used symbol per cycle against the
// forbidden codes and against every later used symbol.
// ----------------------------------------------------------------------------
module sirs_sym_check (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [sirs_pkg::RADIX_W-1:0]  radix_i,
  input  sirs_pkg::sym_table_t          table_i,
  output sirs_pkg::chk_status_t         status_o
);
  import sirs_pkg::*;

  logic               busy_q;
  logic [TIDX_W-1:0]  idx_q;
  logic               range_bad;
  logic               row_bad;
  logic               at_end;
  logic [SYM_W-1:0]   cur;

  assign range_bad = (radix_i < MIN_RADIX) || (radix_i > MAX_RADIX);
  assign cur       = table_i[idx_q];
  assign at_end    = ({1'b0, idx_q} == RADIX_W'(radix_i - RADIX_W'(1)));

  always_comb begin
    row_bad = (cur == SYM_NUL) || (cur == SYM_PLUS) || (cur == SYM_MINUS);
    for (int j = 0; j < TAB_SIZE; j++) begin
      if ((RADIX_W'(j) > {1'b0, idx_q}) && (RADIX_W'(j) < radix_i) &&
          (table_i[j] == cur)) begin
        row_bad = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
    end else if (start_i && !busy_q) begin
      busy_q <= 1'b1;
      idx_q  <= '0;
    end else if (busy_q) begin
      if (range_bad || row_bad || at_end) begin
        busy_q <= 1'b0;
      end else begin
        idx_q <= idx_q + TIDX_W'(1);
      end
    end
  end

  assign status_o.busy = busy_q;
  assign status_o.done = busy_q && (range_bad || row_bad || at_end);
  assign status_o.ok   = !range_bad && !row_bad;

endmodule

>>> design/signed_int_to_radix_symbols_unit.sv
// ----------------------------------------------------------------------------
// signed_int_to_radix_symbols_unit: signed integer to radix symbol stream
// Converts a 32-bit signed value into digit symbols of the configured radix,
// most significant first, led by '-' when negative, last symbol flagged.
// ----------------------------------------------------------------------------
//  channel  dir  handshake        word
//  in_i     in   valid/ready      value[31:0] signed
//  out_o    out  valid/ready      symbol[7:0], last
//  cfg_i    in   valid/ready      index[1:0], data[63:0]
//
// Per value: the symbol set is validated, one symbol per cycle, then each
// digit comes from the shared divider (8 quotient bits a cycle), then the
// sign step runs, on positive values too, then each digit symbol takes a read
// and an emit state, then the unit is idle. An invalid set drops the value.
// Reset is asynchronous, active low; registers return to radix 10, "0".."f".
// in_i is ready only between values; out_o holds its word until taken.
// ----------------------------------------------------------------------------
module signed_int_to_radix_symbols_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  sirs_value_if.sink         in_i,
  sirs_symbol_if.source      out_o,
  sirs_cfg_if.sink           cfg_i
);
  import sirs_pkg::*;

  // Configuration registers
  logic [RADIX_W-1:0]    radix_q;
  logic [CFG_DAT_W-1:0]  sym_low_q;
  logic [CFG_DAT_W-1:0]  sym_high_q;
  sym_table_t            sym_tab;

  // Sequencer and datapath
  state_e               state_q, state_d;
  logic                 neg_q;
  logic [DATA_W-1:0]    mag_q;
  logic [CNT_W-1:0]     cnt_q;
  logic [DIGIT_W-1:0]   rd_q;
  logic [DIGIT_W-1:0]   digit_mem [MAX_DIGITS];
  logic [ADDR_W-1:0]    rd_addr;

  // Output register
  logic                 out_valid_q;
  logic [SYM_W-1:0]     out_sym_q;
  logic                 out_last_q;

  // Control decoded from the state
  logic                 accept_in;
  logic                 out_free;
  logic                 chk_start;
  logic                 div_start;
  logic                 dig_we;
  logic                 out_load;
  logic [SYM_W-1:0]     out_sym_d;
  logic                 out_last_d;
  logic                 div_finish;

  chk_status_t          chk_st;
  div_status_t          div_st;
  logic [DATA_W-1:0]    quot;
  logic [DIGIT_W-1:0]   rem;

  assign sym_tab   = {sym_high_q, sym_low_q};
  assign accept_in = in_i.valid && in_i.ready;
  assign out_free  = !out_valid_q || out_o.ready;
  assign rd_addr   = ADDR_W'(cnt_q - CNT_W'(1));

  // Stop dividing once the magnitude is exhausted or the store is full.
  assign div_finish = div_st.done &&
                      ((quot == '0) || (cnt_q == MAX_DIGITS - CNT_W'(1)));

  // --------------------------------------------------------------------------
  // Shared units
  // --------------------------------------------------------------------------
  sirs_sym_check u_check (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (chk_start),
    .radix_i  (radix_q),
    .table_i  (sym_tab),
    .status_o (chk_st)
  );

  sirs_divider u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (mag_q),
    .divisor_i   (radix_q),
    .status_o    (div_st),
    .quotient_o  (quot),
    .remainder_o (rem)
  );

  // --------------------------------------------------------------------------
  // Configuration writes; always ready, unknown indexes are dropped
  // --------------------------------------------------------------------------
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q    <= RADIX_RESET;
      sym_low_q  <= SYM_LOW_RESET;
      sym_high_q <= SYM_HIGH_RESET;
    end else if (cfg_i.valid && cfg_i.ready) begin
      unique case (cfg_reg_e'(cfg_i.index))
        REG_RADIX:    radix_q    <= cfg_i.data[RADIX_W-1:0];
        REG_SYM_LOW:  sym_low_q  <= cfg_i.data;
        REG_SYM_HIGH: sym_high_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept_in) state_d = S_CHECK;
      end
      S_CHECK: begin
        if (chk_st.done) state_d = chk_st.ok ? S_DIV : S_IDLE;
      end
      S_DIV: begin
        if (div_finish) state_d = S_SIGN;
      end
      S_SIGN: begin
        if (!neg_q || out_free) state_d = S_READ;
      end
      S_READ: begin
        state_d = S_DIGIT;
      end
      S_DIGIT: begin
        if (out_free) state_d = (cnt_q == CNT_W'(1)) ? S_IDLE : S_READ;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // State outputs
  // --------------------------------------------------------------------------
  always_comb begin
    chk_start  = 1'b0;
    div_start  = 1'b0;
    dig_we     = 1'b0;
    out_load   = 1'b0;
    out_sym_d  = SYM_MINUS;
    out_last_d = 1'b0;
    unique case (state_q)
      S_IDLE:  ;
      S_CHECK: chk_start = !chk_st.busy;
      S_DIV: begin
        div_start = !div_st.busy;
        dig_we    = div_st.done;
      end
      S_SIGN: begin
        // emit the sign ahead of the digits
        out_load = neg_q && out_free;
      end
      S_READ:  ;
      S_DIGIT: begin
        out_load   = out_free;
        out_sym_d  = sym_tab[rd_q];
        out_last_d = (cnt_q == CNT_W'(1));
      end
      default: ;
    endcase
  end

  assign in_i.ready = (state_q == S_IDLE);

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      neg_q       <= 1'b0;
      mag_q       <= '0;
      cnt_q       <= '0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (accept_in) begin
        // two's complement magnitude; the most negative value maps to 2^31
        neg_q <= in_i.value[DATA_W-1];
        mag_q <= in_i.value[DATA_W-1] ? (DATA_W'(0) - DATA_W'(in_i.value))
                                      : DATA_W'(in_i.value);
        cnt_q <= '0;
      end else if (dig_we) begin
        mag_q <= quot;
        cnt_q <= cnt_q + CNT_W'(1);
      end else if ((state_q == S_DIGIT) && out_free) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_sym_q  <= out_sym_d;
      out_last_q <= out_last_d;
    end
  end

  // Digit store, least significant digit at address 0
  always_ff @(posedge clk_i) begin
    if (dig_we) begin
      digit_mem[cnt_q[ADDR_W-1:0]] <= rem;
    end
    rd_q <= digit_mem[rd_addr];
  end

  assign out_o.valid  = out_valid_q;
  assign out_o.symbol = out_sym_q;
  assign out_o.last   = out_last_q;

`ifndef NO_ASSERTIONS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= MAX_DIGITS)
    else $error("digit count beyond store depth");

  a_we_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dig_we |-> (cnt_q < MAX_DIGITS))
    else $error("digit write past end of store");

  a_div_valid_radix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> ((radix_q >= MIN_RADIX) && (radix_q <= MAX_RADIX)))
    else $error("divider started with an invalid radix");

  a_digit_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIGIT) |-> (cnt_q != '0))
    else $error("digit emission with empty store");

  a_last_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && out_last_d) |=> (state_q == S_IDLE) && out_o.last)
    else $error("last symbol did not end the value");
`endif

endmodule
